@@ rtl/line_voltage_window_tracker_macros.svh @@
// Assertion macros for the line voltage window tracker.
`ifndef LINE_VOLTAGE_WINDOW_TRACKER_MACROS_SVH
`define LINE_VOLTAGE_WINDOW_TRACKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LVWT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lvwt assertion failed");
`define LVWT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lvwt assertion failed");
`else
`define LVWT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define LVWT_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/lvwt_pkg.sv @@
// Types and constants of the line voltage window tracker.
package lvwt_pkg;

    localparam int THR_BITS      = 12;
    localparam int WEND_BITS     = 8;
    localparam int DIVR_BITS     = 8;
    localparam int COUNT_BITS    = 9;
    localparam int ANGLE_BITS    = 8;
    localparam int PEAK_OUT_BITS = 12;
    localparam int PROD_BITS     = 17;
    localparam int DSTEP_BITS    = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int OUT_DATA_BITS = 24;
    localparam int OUT_PAD_BITS  = OUT_DATA_BITS - PEAK_OUT_BITS - ANGLE_BITS;

    localparam logic [ANGLE_BITS-1:0] ANGLE_MAX  = 8'd180;
    localparam logic [DSTEP_BITS-1:0] DIV_LAST   = 5'(PROD_BITS - 1);
    localparam logic [WEND_BITS-1:0]  WEND_RST   = 8'd240;
    localparam logic [DIVR_BITS-1:0]  DIVR_RST   = 8'd240;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 9'd256;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_END     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ANGLE_DIVISOR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_DIV,
        ST_DONE
    } lvwt_state_t;

endpackage

@@ rtl/line_voltage_window_tracker.sv @@
// Line voltage window tracker: bit-serial peak and conduction angle detector.
// An accepted word is compared MSB first, bit-serially over CMP_BITS = max(SAMPLE_BITS,12)
// bits; a window-closing word then runs the restoring angle divide, one quotient bit per
// cycle, and the result goes to the output register. The next word is taken only after
// that result is loaded; s_axis_tready is high only in the idle state.
// Reset (aresetn low, synchronous): window state and latched results clear to zero,
// zero_threshold to 0, window_end and angle_divisor to 240, output channel empty.
`include "line_voltage_window_tracker_macros.svh"

module line_voltage_window_tracker #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // config write port
    input  logic                                  cfg_wr_en,
    input  logic [lvwt_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [lvwt_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    // sample stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic                                  m_axis_tlast,  // window_done
    output logic [lvwt_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata   // [11:0] peak_value,
                                                                 // [19:12] conduction_angle
);
    import lvwt_pkg::*;

    // Serial compare width covers both the sample and the 12-bit threshold.
    localparam int CMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
    localparam int CNT_BITS = $clog2(CMP_BITS);

    lvwt_state_t state_reg, state_next;

    // config registers
    logic [THR_BITS-1:0]    zero_thr_reg;
    logic [WEND_BITS-1:0]   window_end_reg;
    logic [DIVR_BITS-1:0]   angle_div_reg;

    // window state
    logic [WEND_BITS-1:0]   sample_cnt_reg;
    logic [SAMPLE_BITS-1:0] run_peak_reg;
    logic [COUNT_BITS-1:0]  run_above_reg;
    logic [SAMPLE_BITS-1:0] lat_peak_reg;
    logic [ANGLE_BITS-1:0]  lat_angle_reg;

    // serial compare datapath
    logic [CMP_BITS-1:0]    samp_sh_reg;   // rotates, so it is whole again after the last compare step
    logic [CMP_BITS-1:0]    peak_sh_reg;
    logic [CMP_BITS-1:0]    thr_sh_reg;
    logic [CNT_BITS-1:0]    bit_cnt_reg;
    logic                   pk_dec_reg, pk_gt_reg;
    logic                   th_dec_reg, th_gt_reg;

    // serial divider datapath
    logic [PROD_BITS-1:0]   dvd_sh_reg;
    logic [PROD_BITS-1:0]   quo_sh_reg;
    logic [DIVR_BITS-1:0]   rem_reg;
    logic [DSTEP_BITS-1:0]  div_cnt_reg;
    logic                   close_reg;

    // output register
    logic                      m_valid_reg;
    logic                      m_last_reg;
    logic [OUT_DATA_BITS-1:0]  m_data_reg;

    logic in_acc, out_free, out_load;
    logic cmp_last, div_last;

    // Compare step: decide on the first differing bit, MSB first.
    logic                   a_bit, p_bit, t_bit;
    logic                   pk_gt_fin, th_gt_fin;
    logic [CMP_BITS-1:0]    samp_rot;
    logic [SAMPLE_BITS-1:0] new_peak;
    logic [COUNT_BITS-1:0]  new_above;
    logic                   win_close;

    // Divide step: restoring, one quotient bit per cycle.
    logic [DIVR_BITS:0]     trial;
    logic                   q_bit;
    logic [DIVR_BITS:0]     trial_sub;
    logic [PROD_BITS-1:0]   quo_next;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign cmp_last = (state_reg == ST_CMP) && (bit_cnt_reg == '0);
    assign div_last = (state_reg == ST_DIV) && (div_cnt_reg == '0);

    assign a_bit     = samp_sh_reg[CMP_BITS-1];
    assign p_bit     = peak_sh_reg[CMP_BITS-1];
    assign t_bit     = thr_sh_reg[CMP_BITS-1];
    assign pk_gt_fin = pk_dec_reg ? pk_gt_reg : (a_bit & ~p_bit);
    assign th_gt_fin = th_dec_reg ? th_gt_reg : (a_bit & ~t_bit);
    assign samp_rot  = {samp_sh_reg[CMP_BITS-2:0], samp_sh_reg[CMP_BITS-1]};
    assign new_peak  = pk_gt_fin ? samp_rot[SAMPLE_BITS-1:0] : run_peak_reg;
    assign new_above = run_above_reg + COUNT_BITS'(th_gt_fin);
    // Counter at or above window_end closes (covers window_end lowered mid-window).
    assign win_close = !(sample_cnt_reg < window_end_reg);

    assign trial     = {rem_reg, dvd_sh_reg[PROD_BITS-1]};
    assign q_bit     = (trial >= {1'b0, angle_div_reg});
    assign trial_sub = trial - {1'b0, angle_div_reg};
    assign quo_next  = {quo_sh_reg[PROD_BITS-2:0], q_bit};

    // FSM: next state and handshake
    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (bit_cnt_reg == '0) begin
                    state_next = win_close ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Config, window state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_thr_reg   <= '0;
            window_end_reg <= WEND_RST;
            angle_div_reg  <= DIVR_RST;
            sample_cnt_reg <= '0;
            run_peak_reg   <= '0;
            run_above_reg  <= '0;
            lat_peak_reg   <= '0;
            lat_angle_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                priority if (cfg_index == CFG_ZERO_THRESHOLD) begin
                    zero_thr_reg <= cfg_wdata[THR_BITS-1:0];
                end else if (cfg_index == CFG_WINDOW_END) begin
                    window_end_reg <= cfg_wdata[WEND_BITS-1:0];
                end else if (cfg_index == CFG_ANGLE_DIVISOR) begin
                    angle_div_reg <= cfg_wdata[DIVR_BITS-1:0];
                end else begin
                    // index beyond the map: dropped
                end
            end
            if (cmp_last) begin
                if (win_close) begin
                    lat_peak_reg   <= new_peak;
                    run_peak_reg   <= '0;
                    run_above_reg  <= '0;
                    sample_cnt_reg <= '0;
                end else begin
                    run_peak_reg   <= new_peak;
                    run_above_reg  <= new_above;
                    sample_cnt_reg <= sample_cnt_reg + 1'b1;
                end
            end
            if (div_last) begin
                // divisor zero gives an all-ones quotient, which saturates too
                lat_angle_reg <= (quo_next > PROD_BITS'(ANGLE_MAX)) ? ANGLE_MAX
                                                                    : quo_next[ANGLE_BITS-1:0];
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Serial datapath and output payload.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            samp_sh_reg <= CMP_BITS'(s_axis_tdata[SAMPLE_BITS-1:0]);
            peak_sh_reg <= CMP_BITS'(run_peak_reg);
            thr_sh_reg  <= CMP_BITS'(zero_thr_reg);
            bit_cnt_reg <= CNT_BITS'(CMP_BITS - 1);
            pk_dec_reg  <= 1'b0;
            pk_gt_reg   <= 1'b0;
            th_dec_reg  <= 1'b0;
            th_gt_reg   <= 1'b0;
        end else if (state_reg == ST_CMP) begin
            samp_sh_reg <= samp_rot;
            peak_sh_reg <= {peak_sh_reg[CMP_BITS-2:0], 1'b0};
            thr_sh_reg  <= {thr_sh_reg[CMP_BITS-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
            if (!pk_dec_reg && (a_bit != p_bit)) begin
                pk_dec_reg <= 1'b1;
                pk_gt_reg  <= a_bit;
            end
            if (!th_dec_reg && (a_bit != t_bit)) begin
                th_dec_reg <= 1'b1;
                th_gt_reg  <= a_bit;
            end
        end

        if (cmp_last) begin
            close_reg   <= win_close;
            dvd_sh_reg  <= PROD_BITS'(new_above) * PROD_BITS'(ANGLE_MAX);
            quo_sh_reg  <= '0;
            rem_reg     <= '0;
            div_cnt_reg <= DIV_LAST;
        end else if (state_reg == ST_DIV) begin
            dvd_sh_reg  <= {dvd_sh_reg[PROD_BITS-2:0], 1'b0};
            quo_sh_reg  <= quo_next;
            rem_reg     <= q_bit ? trial_sub[DIVR_BITS-1:0] : trial[DIVR_BITS-1:0];
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end

        if (out_load) begin
            m_last_reg <= close_reg;
            m_data_reg <= {{OUT_PAD_BITS{1'b0}}, lat_angle_reg, PEAK_OUT_BITS'(lat_peak_reg)};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = m_data_reg;

    // accepted word always starts the serial compare
    `LVWT_ASSERT_NXT(a_acc_cmp, aclk, aresetn, in_acc, state_reg == ST_CMP)
    // latched angle stays within its saturated range
    `LVWT_ASSERT_IMP(a_angle_max, aclk, aresetn, 1'b1, lat_angle_reg <= ANGLE_MAX)
    // a window never holds more than 256 conducting words
    `LVWT_ASSERT_IMP(a_above_max, aclk, aresetn, 1'b1, run_above_reg <= COUNT_MAX)
    // restoring divider keeps its remainder below a nonzero divisor
    `LVWT_ASSERT_IMP(a_rem_lt_div, aclk, aresetn,
        (state_reg == ST_DIV) && (angle_div_reg != '0), rem_reg < angle_div_reg)
    // a result is only loaded when the output register can take it
    `LVWT_ASSERT_IMP(a_load_free, aclk, aresetn, out_load, !m_valid_reg || m_axis_tready)

endmodule

@@ test/line_voltage_window_tracker_tb.sv @@
// Self-checking testbench for the line voltage window tracker: stream driver, monitor, predictor.
module line_voltage_window_tracker_tb;
    import lvwt_pkg::*;

    localparam int SAMPLE_W     = 12;
    localparam int IN_DATA_W    = ((SAMPLE_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1800;
    localparam int LONG_HOLD    = 400;      // receiver hold-off, in cycles
    localparam int TAIL_CYCLES  = 40;       // a bit more than the close-word latency
    localparam int RUN_LIMIT    = 400000;   // cycles; several times the slowest clean run
    localparam int MAX_REPORTS  = 10;

    // Index past the register list; the block must ignore writes to it.
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    // One result word as the predictor sees it.
    typedef struct packed {
        logic                     done;
        logic [PEAK_OUT_BITS-1:0] peak;
        logic [ANGLE_BITS-1:0]    angle;
    } window_report_t;

    // Clock, reset, and every DUT input start at a known value.
    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     cfg_wr_en     = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata     = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_W-1:0]     s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic                     m_axis_tlast;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    line_voltage_window_tracker #(
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [11:0] sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast),   // window_done
        .m_axis_tdata  (m_axis_tdata)    // [11:0] peak_value, [19:12] conduction_angle
    );

    always #2 aclk = ~aclk;

    // Sample words waiting for the driver, and result words waiting for the DUT.
    logic [SAMPLE_W-1:0] sample_backlog[$];
    window_report_t      expected_reports[$];

    int unsigned queued_count   = 0;    // words handed to the driver
    int unsigned accepted_count = 0;    // words the DUT took
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;
    logic        word_taken     = 1'b0; // input handshake at the last rising edge

    // Traffic shaping knobs, set by the stimulus process.
    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;

    // Receiver-side hold-off bookkeeping; written only by the receiver process.
    int hold_left = 0;
    bit hold_used = 1'b0;

    // Predictor copy of the configuration (reset values of the block).
    logic [THR_BITS-1:0]  thr_reg  = '0;
    logic [WEND_BITS-1:0] wend_reg = WEND_RST;
    logic [DIVR_BITS-1:0] div_reg  = DIVR_RST;

    // Predictor copy of the window state.
    logic [WEND_BITS-1:0]     win_count  = '0;
    logic [SAMPLE_W-1:0]      win_peak   = '0;
    logic [COUNT_BITS-1:0]    win_above  = '0;
    logic [PEAK_OUT_BITS-1:0] held_peak  = '0;
    logic [ANGLE_BITS-1:0]    held_angle = '0;

    // floor(count*180/divisor), saturated at 180; a zero divisor saturates too.
    function automatic logic [ANGLE_BITS-1:0] angle_from_count(
        input logic [COUNT_BITS-1:0] count,
        input logic [DIVR_BITS-1:0]  divisor
    );
        int unsigned q;
        if (divisor == '0)
            return ANGLE_MAX;
        q = (int'(count) * int'(ANGLE_MAX)) / int'(divisor);
        if (q > int'(ANGLE_MAX))
            q = int'(ANGLE_MAX);
        return ANGLE_BITS'(q);
    endfunction

    // Advance the window by one accepted sample and queue the word it yields.
    task automatic track_sample(input logic [SAMPLE_W-1:0] smp);
        window_report_t rep;
        rep.done = 1'b0;
        if (smp > win_peak)
            win_peak = smp;
        if (smp > thr_reg)
            win_above = win_above + 1'b1;
        // counter above window_end (end lowered mid-window) closes like equal
        if (win_count < wend_reg) begin
            win_count = win_count + 1'b1;
        end else begin
            held_peak  = win_peak;
            held_angle = angle_from_count(win_above, div_reg);
            win_peak   = '0;
            win_above  = '0;
            win_count  = '0;
            rep.done   = 1'b1;
        end
        rep.peak  = held_peak;
        rep.angle = held_angle;
        expected_reports.push_back(rep);
    endtask

    // Driver: new word on the falling edge, held until the DUT takes it.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !word_taken) begin
            // hold the word
        end else if (sample_backlog.size() > 0 && (no_idle || $urandom_range(99) >= 10)) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= IN_DATA_W'(sample_backlog.pop_front());
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random back-pressure plus one long hold-off on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_request && !hold_used) begin
                hold_left = LONG_HOLD;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_idle || $urandom_range(99) >= 10;
            end
        end
    end

    // Monitor: predict on input handshakes, check on output handshakes.
    always @(posedge aclk) begin
        window_report_t got;
        window_report_t want;
        if (!aresetn) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                track_sample(s_axis_tdata[SAMPLE_W-1:0]);
                accepted_count++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.done  = m_axis_tlast;
                got.peak  = m_axis_tdata[PEAK_OUT_BITS-1:0];
                got.angle = m_axis_tdata[PEAK_OUT_BITS+ANGLE_BITS-1:PEAK_OUT_BITS];
                if (expected_reports.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("unexpected word: done=%0d peak=%0d angle=%0d",
                                 got.done, got.peak, got.angle);
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (got.done !== want.done || got.peak !== want.peak ||
                        got.angle !== want.angle) begin
                        if (fail_count < MAX_REPORTS)
                            $display({"mismatch: expected done=%0d peak=%0d angle=%0d,",
                                      " got done=%0d peak=%0d angle=%0d"},
                                     want.done, want.peak, want.angle,
                                     got.done, got.peak, got.angle);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        sample_backlog.push_back(smp);
        queued_count++;
    endtask

    // Sender pause: block until every word is in and every result is out.
    task automatic drain;
        while (accepted_count != queued_count || expected_reports.size() != 0)
            @(posedge aclk);
    endtask

    // Register write, only ever called with the block drained.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ZERO_THRESHOLD: thr_reg  = value[THR_BITS-1:0];
            CFG_WINDOW_END:     wend_reg = value[WEND_BITS-1:0];
            CFG_ANGLE_DIVISOR:  div_reg  = value[DIVR_BITS-1:0];
            default: ;          // out-of-range index: no effect
        endcase
    endtask

    // Random sample biased toward the extremes and the threshold edge.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return thr_reg;
            3:       return SAMPLE_W'(thr_reg + 1'b1);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int unsigned random_sent;
        int unsigned phase;
        int unsigned n;
        logic [THR_BITS-1:0]  thr_v;
        logic [WEND_BITS-1:0] wend_v;
        logic [DIVR_BITS-1:0] div_v;

        random_sent = 0;
        phase       = 0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part.
        // Nothing closed yet: peak and angle read zero.
        send_sample('0);
        send_sample('1);
        drain();

        // Threshold is strict: 2048 does not count, 2049 does.
        write_reg(CFG_ZERO_THRESHOLD, 12'd2048);
        write_reg(CFG_WINDOW_END, 12'hA03);     // upper bits dropped
        write_reg(CFG_ANGLE_DIVISOR, 12'h504);
        send_sample('1);
        send_sample('0);
        send_sample(12'd2048);
        send_sample(12'd2049);
        drain();

        // Window end zero: one-sample windows. Divisor zero: angle pinned at max.
        write_reg(CFG_WINDOW_END, 12'hF00);
        write_reg(CFG_ANGLE_DIVISOR, 12'hF00);
        send_sample(12'hAAA);
        send_sample(12'h555);
        send_sample(12'd1);
        drain();

        // Divisor one saturates the angle.
        write_reg(CFG_ZERO_THRESHOLD, 12'd0);
        write_reg(CFG_WINDOW_END, 12'd5);
        write_reg(CFG_ANGLE_DIVISOR, 12'd1);
        repeat (6) send_sample('1);
        drain();

        // Lower the window end below the running counter mid-window.
        write_reg(CFG_WINDOW_END, 12'd7);
        write_reg(CFG_ANGLE_DIVISOR, 12'd255);
        send_sample(12'd100);
        send_sample(12'd3000);
        send_sample(12'd7);
        drain();
        write_reg(CFG_WINDOW_END, 12'd1);
        send_sample(12'd9);
        send_sample(12'd4000);
        drain();

        // Write past the register list; following words show it changed nothing.
        write_reg(CFG_UNUSED, 12'hFFF);
        send_sample(12'd50);
        send_sample(12'd60);
        drain();

        // Random part: phases of random settings, drained before each rewrite.
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(5))
                0:       thr_v = '0;
                1:       thr_v = '1;
                default: thr_v = THR_BITS'($urandom);
            endcase
            case ($urandom_range(9))
                0:       wend_v = '0;
                1:       wend_v = 8'd255;
                2:       wend_v = 8'd1;
                default: wend_v = WEND_BITS'($urandom_range(2, 24));
            endcase
            case ($urandom_range(7))
                0:       div_v = '0;
                1:       div_v = 8'd1;
                2:       div_v = 8'd255;
                default: div_v = DIVR_BITS'($urandom_range(1, 255));
            endcase
            write_reg(CFG_ZERO_THRESHOLD, thr_v);
            write_reg(CFG_WINDOW_END, {4'($urandom), wend_v});
            write_reg(CFG_ANGLE_DIVISOR, {4'($urandom), div_v});
            if ($urandom_range(7) == 0)
                write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom));

            // long windows need many words to close a few times
            n = (wend_v > 100) ? $urandom_range(260, 540) : $urandom_range(30, 120);
            // keep the total near the planned word count
            if (n > RANDOM_ITEMS - random_sent)
                n = RANDOM_ITEMS - random_sent;
            if (phase == 2) begin
                // receiver stalls long while words keep coming: DUT backs up
                hold_request = 1'b1;
                n = 200;
            end
            no_idle = (phase == 4);   // one stretch with no gaps on either side

            repeat (n) send_sample(pick_sample());
            random_sent += n;
            drain();
            phase++;
        end
        no_idle = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_reports.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lvwt_pkg.sv
rtl/line_voltage_window_tracker.sv
test/line_voltage_window_tracker_tb.sv
